@@ sv/tccs_pkg.sv @@
// Shared types and constants for the text console cursor and scroll engine.
`default_nettype none

package tccs_pkg;

   // Default screen geometry
   localparam int DEFAULT_ROWS = 25;
   localparam int DEFAULT_COLS = 79;

   // Port field widths
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 16;

   // Request kinds
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Cell and character codes
   localparam logic [CELL_W-1:0] CLEAR_CELL   = 16'h1F20;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h1F;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_SCROLL,
      ST_DRAIN
   } tccs_state_type;

endpackage

`default_nettype wire

@@ sv/text_console_cursor_scroll_core.sv @@
// Text console engine: cell store, cursor, put/read requests and scroll sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   req     | in        | req_valid/req_ready  | req_type, req_char_code, req_read_row/col
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_cell_value, rsp_cursor_col/row,
//           |           |                      | rsp_scrolled
//   csr     | in        | csr_valid/csr_ready  | csr_text_attribute (always ready)
//
// A put that does not scroll leaves the sequencer idle; its response is loaded at acceptance.
// A read goes through the registered read port of the cell store, then ST_READ_WAIT loads its response.
// A put that scrolls holds req_ready low through ST_SCROLL and ST_DRAIN: one scan counter
// walks every cell, copying through the store's read port and write port, then blanking.
// After reset a clearing pass writes ROWS*COLS cells (1975 by default) before the
// first request is taken. A stalled response holds req_ready low only while the
// response register cannot be freed in the same cycle.
`default_nettype none

module text_console_cursor_scroll_core
   import tccs_pkg::*;
#(
   parameter int ROWS = DEFAULT_ROWS,
   parameter int COLS = DEFAULT_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ROW_W-1:0]  req_read_row,
   input  logic [COL_W-1:0]  req_read_col,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CELL_W-1:0] rsp_cell_value,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic              rsp_scrolled,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_text_attribute
);

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(ROWS);

   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLS);
   localparam logic [AW-1:0] COLS_A    = AW'(COLS);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

   // Cell store
   logic [CELL_W-1:0] cells_ff [CELLS];
   logic [CELL_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   // Sequencer and scan unit
   tccs_state_type state_ff, state_in;
   logic [AW-1:0]  scan_ff, scan_in;
   logic           cp_valid_ff, cp_valid_in;
   logic [AW-1:0]  cp_addr_ff, cp_addr_in;
   logic           cp_blank_ff, cp_blank_in;

   // Cursor and attribute
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              scroll_start;
   logic [CW:0]       col_inc;

   // Request decode
   logic          req_fire;
   logic          is_put;
   logic          is_newline;
   logic          rd_in_range;
   logic [AW-1:0] rd_addr;
   logic          rd_zero_ff, rd_zero_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic              rsp_scr_ff, rsp_scr_in;
   logic              rsp_load;

   // Handshakes
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign is_put     = (req_type == REQ_PUT);
   assign is_newline = (req_char_code == NEWLINE_CHAR);

   // Read address of the requested cell
   assign rd_in_range = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLS);
   assign rd_addr     = AW'(req_read_row) * COLS_A + AW'(req_read_col);

   // Attribute register
   assign attr_in = csr_valid ? csr_text_attribute : attr_ff;

   // Cursor advance
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      scroll_start = 1'b0;
      col_inc      = {1'b0, col_ff} + 1'b1;
      if (req_fire && is_put) begin
         if (is_newline || (int'(col_inc) >= COLS)) begin
            col_in = '0;
            if (row_ff == LAST_ROW) begin
               scroll_start = 1'b1;
            end else begin
               row_in  = row_ff + 1'b1;
               base_in = base_ff + COLS_A;
            end
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_ff == LAST_CELL) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (!is_put) state_in = ST_READ_WAIT;
               else if (scroll_start) state_in = ST_SCROLL;
            end
         end
         ST_READ_WAIT: state_in = ST_IDLE;
         ST_SCROLL: begin
            if (scan_ff == LAST_CELL) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: store port and scan unit
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      scan_in     = scan_ff;
      cp_valid_in = 1'b0;
      cp_addr_in  = cp_addr_ff;
      cp_blank_in = cp_blank_ff;
      rd_zero_in  = rd_zero_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = CLEAR_CELL;
            scan_in   = scan_ff + 1'b1;
         end
         ST_IDLE: begin
            scan_in = '0;
            if (req_fire && is_put && !is_newline) begin
               mem_we    = 1'b1;
               mem_waddr = base_ff + AW'(col_ff);
               mem_wdata = {attr_ff, req_char_code};
            end
            if (req_fire && !is_put) begin
               mem_re     = rd_in_range;
               mem_raddr  = rd_addr;
               rd_zero_in = !rd_in_range;
            end
         end
         ST_READ_WAIT: ;
         ST_SCROLL: begin
            // read the cell one row below, write it here next cycle
            mem_re      = (scan_ff < LAST_BASE);
            mem_raddr   = scan_ff + COLS_A;
            cp_valid_in = 1'b1;
            cp_addr_in  = scan_ff;
            cp_blank_in = (scan_ff >= LAST_BASE);
            scan_in     = scan_ff + 1'b1;
         end
         ST_DRAIN: ;
         default: ;
      endcase
      // delayed copy or blank write of the scroll pass
      if (cp_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = cp_addr_ff;
         mem_wdata = cp_blank_ff ? {attr_ff, BLANK_CHAR} : rd_data_ff;
      end
   end

   // Response register load
   always_comb begin
      rsp_load   = (req_fire && is_put) || (state_ff == ST_READ_WAIT);
      rsp_cell_in = rsp_cell_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_scr_in  = rsp_scr_ff;
      if (req_fire && is_put) begin
         rsp_cell_in = '0;
         rsp_col_in  = COL_W'(col_in);
         rsp_row_in  = ROW_W'(row_in);
         rsp_scr_in  = scroll_start;
      end else if (state_ff == ST_READ_WAIT) begin
         rsp_cell_in = rd_zero_ff ? '0 : rd_data_ff;
         rsp_col_in  = COL_W'(col_ff);
         rsp_row_in  = ROW_W'(row_ff);
         rsp_scr_in  = 1'b0;
      end
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // Cell store port
   always_ff @(posedge clock) begin
      if (mem_we) cells_ff[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= cells_ff[mem_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         cp_valid_ff  <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cp_valid_ff  <= cp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cp_addr_ff  <= cp_addr_in;
      cp_blank_ff <= cp_blank_in;
      rd_zero_ff  <= rd_zero_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

`default_nettype wire

@@ sv/tccs_checker.sv @@
// Port-level checker for the text console engine, bound to the top level.
`default_nettype none

module tccs_checker
   import tccs_pkg::*;
#(
   parameter int ROWS = DEFAULT_ROWS
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_type,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CELL_W-1:0] rsp_cell_value,
   input wire logic [COL_W-1:0]  rsp_cursor_col,
   input wire logic [ROW_W-1:0]  rsp_cursor_row,
   input wire logic              rsp_scrolled
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
         && $stable(rsp_cursor_col) && $stable(rsp_cursor_row) && $stable(rsp_scrolled))
      else $error("response changed while stalled");

   // A scroll leaves the cursor at the start of the last row, no cell data
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_col == '0
         && rsp_cursor_row == ROW_W'(ROWS - 1) && rsp_cell_value == '0)
      else $error("scroll response with wrong cursor or cell");

   // A put request answers in the next cycle
   a_put_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_PUT |=> rsp_valid)
      else $error("put request not answered in one cycle");

   // Clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request taken before the clearing pass");

endmodule

bind text_console_cursor_scroll_core tccs_checker #(.ROWS(ROWS)) u_tccs_checker (.*);

`default_nettype wire

@@ tb/text_console_cursor_scroll_core_test.sv @@
// Testbench for the text console engine: put/read requests, cursor moves, scrolls.
`default_nettype none

module text_console_cursor_scroll_core_test;
   import tccs_pkg::*;

   localparam int ROWS       = DEFAULT_ROWS;
   localparam int COLS       = DEFAULT_COLS;
   localparam int CELL_COUNT = ROWS * COLS;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } console_response_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_type;
   logic [CHAR_W-1:0] req_char_code;
   logic [ROW_W-1:0]  req_read_row;
   logic [COL_W-1:0]  req_read_col;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   logic [CELL_W-1:0] rsp_cell_value;
   logic [COL_W-1:0]  rsp_cursor_col;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic              rsp_scrolled;
   logic              csr_valid;
   logic              csr_ready;
   logic [ATTR_W-1:0] csr_text_attribute;

   // Shadow of the console state
   logic [CELL_W-1:0] screen_copy [CELL_COUNT];
   int                cursor_col_copy;
   int                cursor_row_copy;
   logic [ATTR_W-1:0] attribute_copy;

   console_response_type expected_responses [$];
   int                   error_count = 0;

   // Receiver stall pattern state
   int stall_mode  = 0;
   int stall_left  = 0;
   int stall_tick  = 0;

   text_console_cursor_scroll_core #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_scrolled       (rsp_scrolled),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop
   initial begin
      #100_000_000;
      $display("text_console_cursor_scroll_core_test NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Move the shadow cursor to the next line; at the bottom, scroll up one row and blank the bottom row
   function automatic bit move_to_next_line();
      int i;
      cursor_col_copy = 0;
      cursor_row_copy++;
      if (cursor_row_copy >= ROWS) begin
         cursor_row_copy = ROWS - 1;
         for (i = 0; i < (ROWS - 1) * COLS; i++) screen_copy[i] = screen_copy[i + COLS];
         for (i = (ROWS - 1) * COLS; i < CELL_COUNT; i++)
            screen_copy[i] = {attribute_copy, BLANK_CHAR};
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one accepted request to the shadow state and queue its response
   function automatic void predict_console_request(input logic kind,
         input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] row,
         input logic [COL_W-1:0] col);
      console_response_type res;
      res = '0;
      if (kind == REQ_READ) begin
         if (int'(row) < ROWS && int'(col) < COLS)
            res.cell_value = screen_copy[int'(row) * COLS + int'(col)];
      end else if (ch == NEWLINE_CHAR) begin
         res.scrolled = move_to_next_line();
      end else begin
         screen_copy[cursor_row_copy * COLS + cursor_col_copy] = {attribute_copy, ch};
         cursor_col_copy++;
         if (cursor_col_copy >= COLS) res.scrolled = move_to_next_line();
      end
      res.cursor_col = cursor_col_copy[COL_W-1:0];
      res.cursor_row = cursor_row_copy[ROW_W-1:0];
      expected_responses.push_back(res);
   endfunction

   // Send one request; valid stays high afterwards when another follows directly
   task automatic send_request(input logic kind, input logic [CHAR_W-1:0] ch,
         input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col, input bit more);
      req_type      = kind;
      req_char_code = ch;
      req_read_row  = row;
      req_read_col  = col;
      req_valid     = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_console_request(kind, ch, row, col);
      @(negedge clock);
      if (!more) req_valid = 1'b0;
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch, input bit more);
      send_request(REQ_PUT, ch, ROW_W'($urandom), COL_W'($urandom), more);
   endtask

   task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
         input bit more);
      send_request(REQ_READ, CHAR_W'($urandom), row, col, more);
   endtask

   // Wait for every response, then for the block to finish any scroll
   task automatic drain_responses();
      while (expected_responses.size() != 0) @(negedge clock);
      while (!req_ready) @(negedge clock);
   endtask

   task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
      drain_responses();
      csr_text_attribute = value;
      csr_valid          = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      attribute_copy = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic read_whole_row(input int row);
      int c;
      for (c = 0; c < COLS; c++) read_cell(ROW_W'(row), COL_W'(c), c < COLS - 1);
      @(negedge clock);
   endtask

   // Field extremes, both request kinds, out-of-screen reads, newline and char 0
   task automatic test_field_extremes();
      read_cell(ROW_W'(0), COL_W'(0), 1'b1);
      read_cell(ROW_W'(ROWS - 1), COL_W'(COLS - 1), 1'b1);
      read_cell(ROW_W'(ROWS), COL_W'(0), 1'b1);
      read_cell('1, '1, 1'b1);
      read_cell(ROW_W'(0), COL_W'(COLS), 1'b1);
      read_cell(ROW_W'(ROWS - 1), '1, 1'b0);
      @(negedge clock);
      put_char(8'h00, 1'b1);
      put_char(8'hFF, 1'b1);
      put_char(8'h41, 1'b1);
      read_cell(ROW_W'(0), COL_W'(0), 1'b1);
      read_cell(ROW_W'(0), COL_W'(1), 1'b1);
      read_cell(ROW_W'(0), COL_W'(2), 1'b1);
      read_cell(ROW_W'(0), COL_W'(3), 1'b1);
      put_char(NEWLINE_CHAR, 1'b1);
      put_char(NEWLINE_CHAR, 1'b0);
      @(negedge clock);
      write_text_attribute(8'h00);
      put_char(8'h55, 1'b1);
      put_char(8'hAA, 1'b1);
      read_cell(ROW_W'(2), COL_W'(0), 1'b1);
      read_cell(ROW_W'(2), COL_W'(1), 1'b1);
      read_cell(ROW_W'(2), COL_W'(2), 1'b0);
      @(negedge clock);
   endtask

   // A full row of text wraps to the next row without a newline
   task automatic test_row_wrap();
      int c;
      put_char(NEWLINE_CHAR, 1'b1);
      for (c = 0; c < COLS; c++) put_char(CHAR_W'($urandom), c < COLS - 1);
      @(negedge clock);
      read_cell(ROW_W'(cursor_row_copy - 1), COL_W'(COLS - 1), 1'b0);
      @(negedge clock);
   endtask

   // Scroll by newline and by a full bottom row, then inspect the bottom two rows and the top row
   task automatic test_scroll();
      int c;
      write_text_attribute(8'hFF);
      while (cursor_row_copy != ROWS - 1) put_char(NEWLINE_CHAR, 1'b1);
      put_char(8'h31, 1'b1);
      put_char(NEWLINE_CHAR, 1'b0);
      @(negedge clock);
      for (c = 0; c < COLS; c++) put_char(CHAR_W'($urandom_range(33, 126)), c < COLS - 1);
      @(negedge clock);
      read_whole_row(ROWS - 2);
      read_whole_row(ROWS - 1);
      read_whole_row(0);
   endtask

   // Pick one request: mostly text, some read-backs, random cell reads and stray reads
   task automatic pick_request(output logic kind, output logic [CHAR_W-1:0] ch,
         output logic [ROW_W-1:0] row, output logic [COL_W-1:0] col);
      int r;
      r    = $urandom_range(0, 99);
      kind = REQ_PUT;
      ch   = CHAR_W'($urandom);
      row  = ROW_W'($urandom);
      col  = COL_W'($urandom);
      if (r < 68) begin
         if ($urandom_range(0, 24) == 0) ch = NEWLINE_CHAR;
      end else if (r < 80) begin
         kind = REQ_READ;
         row  = ROW_W'(cursor_row_copy);
         col  = COL_W'((cursor_col_copy == 0) ? 0 : cursor_col_copy - 1);
      end else if (r < 94) begin
         kind = REQ_READ;
         row  = ROW_W'($urandom_range(0, ROWS - 1));
         col  = COL_W'($urandom_range(0, COLS - 1));
      end else begin
         kind = REQ_READ;
      end
   endtask

   // Bursts of random requests with random gaps and an occasional full drain
   task automatic test_random_traffic(input logic [ATTR_W-1:0] attr, input int item_total);
      int                sent;
      int                burst_len;
      int                k;
      logic              kind;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      write_text_attribute(attr);
      sent = 0;
      while (sent < item_total) begin
         burst_len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(1, 12);
         for (k = 0; k < burst_len && sent < item_total; k++) begin
            pick_request(kind, ch, row, col);
            send_request(kind, ch, row, col, (k < burst_len - 1) && (sent + 1 < item_total));
            sent++;
         end
         if ($urandom_range(0, 39) == 0) drain_responses();
         else repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Receiver stall pattern: a new random mode is picked whenever the current one runs out
   always @(negedge clock) begin
      stall_tick++;
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         2: rsp_ready = ($urandom_range(0, 3) != 0);
         default: rsp_ready = (stall_tick % 8 == 0);
      endcase
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin : check_responses
      console_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = expected_responses.pop_front();
            if (rsp_cell_value !== want.cell_value)
               report_mismatch($sformatf("cell_value got %h want %h",
                  rsp_cell_value, want.cell_value));
            if (rsp_cursor_col !== want.cursor_col)
               report_mismatch($sformatf("cursor_col got %0d want %0d",
                  rsp_cursor_col, want.cursor_col));
            if (rsp_cursor_row !== want.cursor_row)
               report_mismatch($sformatf("cursor_row got %0d want %0d",
                  rsp_cursor_row, want.cursor_row));
            if (rsp_scrolled !== want.scrolled)
               report_mismatch($sformatf("scrolled got %b want %b",
                  rsp_scrolled, want.scrolled));
         end
      end
   end

   initial begin : run_tests
      int i;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_type           = REQ_PUT;
      req_char_code      = '0;
      req_read_row       = '0;
      req_read_col       = '0;
      csr_valid          = 1'b0;
      csr_text_attribute = '0;
      for (i = 0; i < CELL_COUNT; i++) screen_copy[i] = CLEAR_CELL;
      cursor_col_copy = 0;
      cursor_row_copy = 0;
      attribute_copy  = ATTR_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_field_extremes();
      test_row_wrap();
      test_scroll();
      test_random_traffic(ATTR_W'($urandom), 365);
      test_random_traffic(8'h00, 365);
      test_random_traffic(8'hFF, 365);
      test_random_traffic(ATTR_RESET, 365);

      // Let any stray response show up before the verdict
      drain_responses();
      repeat (20) @(negedge clock);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("text_console_cursor_scroll_core_test OK");
      end else begin
         $display("text_console_cursor_scroll_core_test NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
